FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the framed command switch controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent and consequent in the same cycle
`define FCSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent in the cycle after the antecedent
`define FCSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define FCSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FCSC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/fcsc_pkg.sv
// Types and constants of the framed command switch controller
package fcsc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PREAMBLE_A   = 8'hAA;
  localparam logic [7:0] PREAMBLE_B   = 8'h55;
  localparam logic [7:0] ADDR_BCAST   = 8'hFF;
  localparam logic [7:0] ADDR_NONE    = 8'h00;
  localparam logic [7:0] REPLY_REJECT = 8'hEE;
  localparam logic [7:0] REPLY_OK     = 8'h00;

  localparam logic [7:0] CMD_SET_ADDR = 8'h01;
  localparam logic [7:0] CMD_SWITCH   = 8'h02;
  localparam logic [7:0] CMD_BOOT     = 8'h03;

  // switch command data layout
  localparam int SW_TRX_BIT = 7;
  localparam int SW_EN_BIT  = 3;

  // reset values of the held state
  localparam logic [7:0] RST_ADDRESS = 8'h01;
  localparam logic       RST_TX      = 1'b1;
  localparam logic       RST_RX      = 1'b0;
  localparam logic [2:0] RST_PHASE   = 3'd7;

  // reply byte positions
  localparam logic [2:0] IDX_PRE0 = 3'd0;
  localparam logic [2:0] IDX_PRE1 = 3'd1;
  localparam logic [2:0] IDX_CMD  = 3'd2;
  localparam logic [2:0] IDX_ADDR = 3'd3;
  localparam logic [2:0] IDX_DATA = 3'd4;
  localparam logic [2:0] IDX_SUM  = 3'd5;

  localparam logic [1:0] BODY_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GOT_AA,
    PH_BODY
  } parse_phase_t;

  // one pending reply, with the switch state it reports
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] sum;
    logic       tx_en;
    logic       rx_en;
    logic [2:0] phase_one;
    logic [2:0] phase_two;
    logic       boot;
  } reply_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: hdl/fcsc_rx_if.sv
// Received byte channel
interface fcsc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/fcsc_tx_if.sv
// Reply byte channel with the switch state
interface fcsc_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic       tx_enable;
  logic       rx_enable;
  logic [2:0] phase_one;
  logic [2:0] phase_two;
  logic [7:0] device_address;
  logic       enter_bootloader;

  modport source (output valid, output tx_byte, output last_byte, output tx_enable,
                  output rx_enable, output phase_one, output phase_two,
                  output device_address, output enter_bootloader, input ready);
  modport sink (input valid, input tx_byte, input last_byte, input tx_enable,
                input rx_enable, input phase_one, input phase_two,
                input device_address, input enter_bootloader, output ready);
endinterface

FILE: hdl/fcsc_front.sv
// Frame parser, command decode and held switch state
module fcsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  output logic              push,
  output fcsc_pkg::reply_t  push_reply
);

  fcsc_pkg::parse_phase_t phase_r, phase_nxt;
  logic [1:0] body_count_r, body_count_nxt;
  logic [7:0] body_r [0:2];

  logic [7:0] own_address_r, own_address_nxt;
  logic       tx_r, tx_nxt;
  logic       rx_r, rx_nxt;
  logic [2:0] ph1_r, ph1_nxt;
  logic [2:0] ph2_r, ph2_nxt;

  logic       store_en;
  logic       frame_end;
  logic [7:0] sum_calc;
  logic       frame_ok;
  logic [7:0] reply_data;
  logic       boot;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      fcsc_pkg::PH_IDLE: begin
        if (in_byte == fcsc_pkg::PREAMBLE_A) phase_nxt = fcsc_pkg::PH_GOT_AA;
      end
      fcsc_pkg::PH_GOT_AA: begin
        // a mismatching byte is dropped, not re-examined as AA
        phase_nxt = (in_byte == fcsc_pkg::PREAMBLE_B) ? fcsc_pkg::PH_BODY
                                                      : fcsc_pkg::PH_IDLE;
      end
      fcsc_pkg::PH_BODY: begin
        if (body_count_r == fcsc_pkg::BODY_LAST) phase_nxt = fcsc_pkg::PH_IDLE;
      end
      default: phase_nxt = fcsc_pkg::PH_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    store_en       = 1'b0;
    frame_end      = 1'b0;
    body_count_nxt = body_count_r;
    case (phase_r)
      fcsc_pkg::PH_IDLE:   body_count_nxt = '0;
      fcsc_pkg::PH_GOT_AA: body_count_nxt = '0;
      fcsc_pkg::PH_BODY: begin
        frame_end      = (body_count_r == fcsc_pkg::BODY_LAST);
        store_en       = !frame_end;
        body_count_nxt = body_count_r + 2'd1;
      end
      default: body_count_nxt = '0;
    endcase
  end

  // judge the frame, the sum byte being the current one
  always_comb begin
    sum_calc = body_r[0] + body_r[1] + body_r[2];
    frame_ok = (sum_calc == in_byte) &&
               (body_r[1] == own_address_r || body_r[1] == fcsc_pkg::ADDR_BCAST);

    own_address_nxt = own_address_r;
    tx_nxt          = tx_r;
    rx_nxt          = rx_r;
    ph1_nxt         = ph1_r;
    ph2_nxt         = ph2_r;
    reply_data      = fcsc_pkg::REPLY_REJECT;
    boot            = 1'b0;
    case (body_r[0])
      fcsc_pkg::CMD_SET_ADDR: begin
        if (!(body_r[2] inside {fcsc_pkg::ADDR_NONE, fcsc_pkg::ADDR_BCAST})) begin
          own_address_nxt = body_r[2];
          reply_data      = body_r[2];
        end
      end
      fcsc_pkg::CMD_SWITCH: begin
        tx_nxt     = body_r[2][fcsc_pkg::SW_TRX_BIT] & body_r[2][fcsc_pkg::SW_EN_BIT];
        rx_nxt     = ~body_r[2][fcsc_pkg::SW_TRX_BIT] & body_r[2][fcsc_pkg::SW_EN_BIT];
        ph1_nxt    = body_r[2][6:4];
        ph2_nxt    = body_r[2][2:0];
        reply_data = fcsc_pkg::REPLY_OK;
      end
      fcsc_pkg::CMD_BOOT: begin
        if (body_r[2] == fcsc_pkg::REPLY_OK) begin
          reply_data = fcsc_pkg::REPLY_OK;
          boot       = 1'b1;
        end
      end
      default: reply_data = fcsc_pkg::REPLY_REJECT;
    endcase

    push_reply.cmd       = body_r[0];
    push_reply.addr      = own_address_nxt;
    push_reply.data      = reply_data;
    push_reply.sum       = body_r[0] + own_address_nxt + reply_data;
    push_reply.tx_en     = tx_nxt;
    push_reply.rx_en     = rx_nxt;
    push_reply.phase_one = ph1_nxt;
    push_reply.phase_two = ph2_nxt;
    push_reply.boot      = boot;
  end

  assign push = in_fire && frame_end && frame_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= fcsc_pkg::PH_IDLE;
      body_count_r  <= '0;
      own_address_r <= fcsc_pkg::RST_ADDRESS;
      tx_r          <= fcsc_pkg::RST_TX;
      rx_r          <= fcsc_pkg::RST_RX;
      ph1_r         <= fcsc_pkg::RST_PHASE;
      ph2_r         <= fcsc_pkg::RST_PHASE;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        body_count_r <= body_count_nxt;
      end
      if (push) begin
        own_address_r <= own_address_nxt;
        tx_r          <= tx_nxt;
        rx_r          <= rx_nxt;
        ph1_r         <= ph1_nxt;
        ph2_r         <= ph2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && store_en) body_r[body_count_r] <= in_byte;
  end

endmodule

FILE: hdl/fcsc_queue.sv
// Short queue of pending replies between parser and serializer
module fcsc_queue #(
  parameter int DEPTH = fcsc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fcsc_pkg::reply_t  push_reply,
  input  logic              pop,
  output fcsc_pkg::reply_t  head,
  output fcsc_pkg::qstat_t  stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fcsc_pkg::reply_t mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_reply;
  end

  assign head       = mem[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

FILE: hdl/fcsc_back.sv
// Reply serializer: six bytes per pending reply, held in an output register
module fcsc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fcsc_pkg::reply_t  head,
  input  fcsc_pkg::qstat_t  stat,
  output logic              pop,
  fcsc_tx_if.source         out_chan
);

  fcsc_pkg::reply_t cur_r;
  logic       busy_r, busy_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_fire;
  logic       at_last;

  assign out_fire = out_chan.valid && out_chan.ready;
  assign at_last  = (idx_r == fcsc_pkg::IDX_SUM);
  assign pop      = !stat.empty && (!busy_r || (out_fire && at_last));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = fcsc_pkg::IDX_PRE0;
    end else if (out_fire) begin
      if (at_last) busy_nxt = 1'b0;
      else idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= fcsc_pkg::IDX_PRE0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

  always_comb begin
    case (idx_r)
      fcsc_pkg::IDX_PRE0: out_chan.tx_byte = fcsc_pkg::PREAMBLE_B;
      fcsc_pkg::IDX_PRE1: out_chan.tx_byte = fcsc_pkg::PREAMBLE_A;
      fcsc_pkg::IDX_CMD:  out_chan.tx_byte = cur_r.cmd;
      fcsc_pkg::IDX_ADDR: out_chan.tx_byte = cur_r.addr;
      fcsc_pkg::IDX_DATA: out_chan.tx_byte = cur_r.data;
      fcsc_pkg::IDX_SUM:  out_chan.tx_byte = cur_r.sum;
      default:            out_chan.tx_byte = cur_r.sum;
    endcase
  end

  assign out_chan.valid            = busy_r;
  assign out_chan.last_byte        = at_last;
  assign out_chan.tx_enable        = cur_r.tx_en;
  assign out_chan.rx_enable        = cur_r.rx_en;
  assign out_chan.phase_one        = cur_r.phase_one;
  assign out_chan.phase_two        = cur_r.phase_two;
  assign out_chan.device_address   = cur_r.addr;
  assign out_chan.enter_bootloader = at_last && cur_r.boot;

endmodule

FILE: hdl/framed_command_switch_controller.sv
// Framed command switch controller: parser, reply queue and serializer
//
// in_chan takes received bytes; a byte is taken when valid and ready are
// both high. Frames are AA 55 type dest data sum. A good frame addressed to
// this unit (own address or FF) is acted on when its sum byte is taken.
// out_chan then carries the six-byte reply 55 AA type address data sum, with
// last_byte on the sum byte and the switch state after the command on every
// byte; enter_bootloader marks the last byte of an accepted boot request.
// One received byte is taken per cycle while in_chan.ready is high. The
// first reply byte is valid after queue write, then serializer load;
// replies go out at one byte per cycle, set by the serializer's byte counter.
// A stalled receiver holds the current reply byte; further replies wait in
// the queue (QUEUE_DEPTH entries) and in_chan.ready drops only while it is
// full. Synchronous reset returns the parser to idle, empties the queue and
// restores address 01, TX on, RX off and both phase codes 7.
module framed_command_switch_controller #(
  parameter int QUEUE_DEPTH = fcsc_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  fcsc_rx_if.sink   in_chan,
  fcsc_tx_if.source out_chan
);

  `include "assert_macros.svh"

  logic             in_fire;
  logic             push;
  logic             pop;
  fcsc_pkg::reply_t push_reply;
  fcsc_pkg::reply_t head;
  fcsc_pkg::qstat_t stat;

  assign in_chan.ready = !stat.full;
  assign in_fire       = in_chan.valid && in_chan.ready;

  fcsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_chan.rx_byte),
    .push       (push),
    .push_reply (push_reply)
  );

  fcsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_reply (push_reply),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  fcsc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  `FCSC_ASSERT_IMP(a_boot_on_last, clk, rst_n,
    out_chan.valid && out_chan.enter_bootloader, out_chan.last_byte)
  `FCSC_ASSERT_IMP(a_addr_legal, clk, rst_n, out_chan.valid,
    out_chan.device_address != fcsc_pkg::ADDR_NONE && out_chan.device_address != fcsc_pkg::ADDR_BCAST)
  `FCSC_ASSERT_IMP(a_paths_exclusive, clk, rst_n, out_chan.valid,
    !(out_chan.tx_enable && out_chan.rx_enable))
  `FCSC_ASSERT_NXT(a_push_fills, clk, rst_n, push && !pop, !stat.empty)

endmodule

FILE: tb/framed_command_switch_controller_tb.sv
// Self-checking testbench for the framed command switch controller
module framed_command_switch_controller_tb;
  import fcsc_pkg::*;

  localparam int RX_BYTES    = 370;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR       = 5;

  // one reply byte as it appears on the result channel
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       tx_enable;
    logic       rx_enable;
    logic [2:0] phase_one;
    logic [2:0] phase_two;
    logic [7:0] device_address;
    logic       enter_bootloader;
  } reply_beat_t;

  // directed request: up to six bytes, optional hand-typed reply data
  typedef struct packed {
    logic [2:0]  len;
    logic [47:0] seq;
    logic        typed;
    logic [7:0]  want_data;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // AA AA 55: second AA drops the parser to idle, the 55 is then ignored
    '{3'd3, {PREAMBLE_A, PREAMBLE_A, PREAMBLE_B, 24'h0}, 1'b0, REPLY_OK},
    // boot request as the first frame after reset, to the reset address
    '{3'd6, {PREAMBLE_A, PREAMBLE_B, CMD_BOOT, RST_ADDRESS, REPLY_OK, 8'h04},
      1'b1, REPLY_OK},
    // broadcast address change to the top legal value
    '{3'd6, {PREAMBLE_A, PREAMBLE_B, CMD_SET_ADDR, ADDR_BCAST, 8'hFE, 8'hFE},
      1'b1, 8'hFE},
    // switch with every data bit set
    '{3'd6, {PREAMBLE_A, PREAMBLE_B, CMD_SWITCH, 8'hFE, 8'hFF, 8'hFF}, 1'b1, REPLY_OK},
    // unknown command, all ones
    '{3'd6, {PREAMBLE_A, PREAMBLE_B, 8'hFF, ADDR_BCAST, 8'hFF, 8'hFD},
      1'b1, REPLY_REJECT}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fcsc_rx_if rx_if ();
  fcsc_tx_if tx_if ();

  framed_command_switch_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (rx_if),
    .out_chan(tx_if)
  );

  always #5 clk = ~clk;

  // tracked state of the unit
  parse_phase_t cur_phase = PH_IDLE;
  logic [2:0]   body_cnt = '0;
  logic [7:0]   body [4];
  logic [7:0]   own_addr = RST_ADDRESS;
  logic         tx_on = RST_TX;
  logic         rx_on = RST_RX;
  logic [2:0]   phase_a = RST_PHASE;
  logic [2:0]   phase_b = RST_PHASE;

  reply_beat_t due_reply_bytes [$];
  int          pushed_total = 0;
  int          fails = 0;
  int          bytes_sent = 0;
  int          replies_seen = 0;
  int          boot_flags = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  task automatic queue_reply(input logic [7:0] cmd, input logic [7:0] data,
                             input logic boot);
    logic [7:0]  bytes [6];
    reply_beat_t beat;
    bytes[IDX_PRE0] = PREAMBLE_B;
    bytes[IDX_PRE1] = PREAMBLE_A;
    bytes[IDX_CMD]  = cmd;
    bytes[IDX_ADDR] = own_addr;
    bytes[IDX_DATA] = data;
    bytes[IDX_SUM]  = cmd + own_addr + data;
    for (int k = 0; k < 6; k++) begin
      beat.tx_byte          = bytes[k];
      beat.last_byte        = (k == IDX_SUM);
      beat.tx_enable        = tx_on;
      beat.rx_enable        = rx_on;
      beat.phase_one        = phase_a;
      beat.phase_two        = phase_b;
      beat.device_address   = own_addr;
      beat.enter_bootloader = (k == IDX_SUM) && boot;
      due_reply_bytes.push_back(beat);
    end
    pushed_total++;
  endtask

  task automatic judge_frame();
    logic [7:0] cmd, dest, data, chk;
    cmd  = body[0];
    dest = body[1];
    data = body[2];
    chk  = cmd + dest + data;
    if (chk == body[3] && (dest == own_addr || dest == ADDR_BCAST)) begin
      case (cmd)
        CMD_SET_ADDR: begin
          if (data == ADDR_NONE || data == ADDR_BCAST) begin
            queue_reply(cmd, REPLY_REJECT, 1'b0);
          end else begin
            own_addr = data;
            queue_reply(cmd, own_addr, 1'b0);
          end
        end
        CMD_SWITCH: begin
          tx_on   = data[SW_TRX_BIT] & data[SW_EN_BIT];
          rx_on   = ~data[SW_TRX_BIT] & data[SW_EN_BIT];
          phase_a = data[6:4];
          phase_b = data[2:0];
          queue_reply(cmd, REPLY_OK, 1'b0);
        end
        CMD_BOOT: begin
          if (data != REPLY_OK) queue_reply(cmd, REPLY_REJECT, 1'b0);
          else queue_reply(cmd, REPLY_OK, 1'b1);
        end
        default: queue_reply(cmd, REPLY_REJECT, 1'b0);
      endcase
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    case (cur_phase)
      PH_IDLE: begin
        if (b == PREAMBLE_A) cur_phase = PH_GOT_AA;
      end
      PH_GOT_AA: begin
        if (b == PREAMBLE_B) begin
          cur_phase = PH_BODY;
          body_cnt  = '0;
        end else begin
          cur_phase = PH_IDLE;
        end
      end
      PH_BODY: begin
        body[body_cnt[1:0]] = b;
        body_cnt = body_cnt + 3'd1;
        if (body_cnt >= 3'd4) begin
          cur_phase = PH_IDLE;
          body_cnt  = '0;
          judge_frame();
        end
      end
      default: begin
        cur_phase = PH_IDLE;
        body_cnt  = '0;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // mostly well-formed requests, some line noise and broken preambles
  task automatic send_random_burst();
    int         pick, n;
    logic [7:0] cmd, dest, data, chk;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 14) begin
      data = 8'($urandom_range(0, 255));
      if (data == PREAMBLE_B) data = PREAMBLE_A;
      send_byte(PREAMBLE_A);
      send_byte(data);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 3) cmd = CMD_SET_ADDR;
      else if (pick < 6) cmd = CMD_SWITCH;
      else if (pick < 8) cmd = CMD_BOOT;
      else if (pick < 9) cmd = 8'h00;
      else cmd = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 6) dest = own_addr;
      else if (pick < 9) dest = ADDR_BCAST;
      else dest = 8'($urandom_range(0, 255));
      data = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 5);
      if (cmd == CMD_SET_ADDR && pick == 0) data = ADDR_NONE;
      if (cmd == CMD_SET_ADDR && pick == 1) data = ADDR_BCAST;
      if (cmd == CMD_BOOT && pick < 3) data = REPLY_OK;
      chk = cmd + dest + data;
      if ($urandom_range(0, 99) < 8) chk = 8'($urandom_range(0, 255));
      send_byte(PREAMBLE_A);
      send_byte(PREAMBLE_B);
      send_byte(cmd);
      send_byte(dest);
      send_byte(data);
      send_byte(chk);
    end
  endtask

  task automatic check_reply_beat();
    reply_beat_t got, want;
    got = '{tx_if.tx_byte, tx_if.last_byte, tx_if.tx_enable, tx_if.rx_enable,
            tx_if.phase_one, tx_if.phase_two, tx_if.device_address,
            tx_if.enter_bootloader};
    if (got.last_byte) replies_seen++;
    if (got.enter_bootloader) boot_flags++;
    if (due_reply_bytes.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected reply byte %h (no reply pending)", got.tx_byte);
    end else begin
      want = due_reply_bytes.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("reply mismatch: byte %h/%h last %b/%b tx %b/%b rx %b/%b",
                   want.tx_byte, got.tx_byte, want.last_byte, got.last_byte,
                   want.tx_enable, got.tx_enable, want.rx_enable, got.rx_enable);
          $display("  (exp/got) ph1 %0d/%0d ph2 %0d/%0d addr %h/%h boot %b/%b",
                   want.phase_one, got.phase_one, want.phase_two, got.phase_two,
                   want.device_address, got.device_address,
                   want.enter_bootloader, got.enter_bootloader);
        end
      end
    end
  endtask

  // reply sink with random stall bursts
  always @(posedge clk) begin
    if (rst_n && tx_if.valid && tx_if.ready) check_reply_beat();
    if (!rst_n) begin
      tx_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      tx_if.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      tx_if.ready <= 1'b0;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      tx_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reply bytes pending",
               cycle_count, due_reply_bytes.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int mark;
    bit drained;
    drained = 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      mark = pushed_total;
      for (int k = 0; k < DIR_ROWS[r].len; k++) send_byte(DIR_ROWS[r].seq[47 - 8 * k -: 8]);
      if (DIR_ROWS[r].typed) begin
        if (pushed_total == mark + 1) begin
          due_reply_bytes[due_reply_bytes.size() - 2].tx_byte = DIR_ROWS[r].want_data;
        end else begin
          fails++;
          $display("directed request %0d was not answered", r);
        end
      end
    end

    while (bytes_sent < RX_BYTES) begin
      if (!drained && bytes_sent >= RX_BYTES / 2) begin
        // hold the line until every pending reply has drained
        rx_if.valid <= 1'b0;
        while (due_reply_bytes.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      calm = (bytes_sent >= RX_BYTES * 4 / 5);
      send_random_burst();
    end
    rx_if.valid <= 1'b0;

    while (due_reply_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d received bytes, checked %0d replies (%0d bootloader flags)",
             bytes_sent, replies_seen, boot_flags);
    $display("final address %h, tx %b rx %b, phases %0d/%0d, %0d mismatches",
             own_addr, tx_on, rx_on, phase_a, phase_b, fails);
    if (fails == 0 && due_reply_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
